### rtl/slf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slf_pkg
// Shared types and constants for the single-linkage union-find block.
// ----------------------------------------------------------------------------
package slf_pkg;

	localparam int MAX_POINTS = 1024;

	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int LBL_W  = 10;
	localparam int RANK_W = 4;
	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_EDGE  = 2'd1;
	localparam logic [1:0] CMD_LABEL = 2'd2;

	localparam logic REG_POINT_COUNT = 1'b0;
	localparam logic REG_TARGET      = 1'b1;

	typedef enum logic [1:0] {
		OP_START,
		OP_EDGE,
		OP_LABEL,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
	} work_t;

endpackage
`default_nettype wire

### rtl/slf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slf_front
// Accepts items, classifies them, and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module slf_front
	import slf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       command,
	input  wire logic [IDX_W-1:0] point_index,
	input  wire logic [IDX_W-1:0] neighbor_index,
	input  wire logic             neighbor_valid,
	input  wire logic [CNT_W-1:0] n_eff,
	input  wire logic             hold,
	output logic                  q_valid,
	output work_t                 q_item,
	input  wire logic             q_pop
);

	work_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	work_t      item;
	logic       push;
	logic       a_in;
	logic       b_in;

	assign a_in = {1'b0, point_index} < n_eff;
	assign b_in = {1'b0, neighbor_index} < n_eff;

	always_comb begin
		item.a = point_index;
		item.b = neighbor_index;
		unique case (command)
			CMD_START: item.op = OP_START;
			CMD_EDGE: item.op = (neighbor_valid && neighbor_index > point_index && a_in && b_in)
					? OP_EDGE : OP_NOP;
			CMD_LABEL: item.op = a_in ? OP_LABEL : OP_NOP;
			default: item.op = OP_NOP;
		endcase
	end

	assign in_ready = (fill_q != 2'd2) && !hold;
	assign push     = in_valid && in_ready;
	assign q_valid  = fill_q != 2'd0;
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (q_pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/slf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slf_back
// Union-find engine: forest memory, find walks with path halving, union by
// rank, labeling, the clearing sweep, and the output register.
// ----------------------------------------------------------------------------
module slf_back
	import slf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CNT_W-1:0] n_eff,
	input  wire logic [CNT_W-1:0] target,
	input  wire logic             q_valid,
	input  wire work_t            q_item,
	output logic                  q_pop,
	output logic                  sweep_init,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  merged,
	output logic [CNT_W-1:0]      components,
	output logic                  stopped,
	output logic [LBL_W-1:0]      cluster_label
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam logic [AW-1:0] LAST = AW'(MAX_POINTS - 1);
	localparam int RST_CNT = (MAX_POINTS < 1024) ? MAX_POINTS : 1024;

	typedef struct packed {
		logic              lvalid;
		logic [LBL_W-1:0]  label;
		logic [RANK_W-1:0] rank;
		logic [AW-1:0]     parent;
	} entry_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WX,
		S_WP,
		S_RANK,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_L
	} phase_t;

	entry_t mem [MAX_POINTS];
	entry_t rdata;

	state_t           state_q;
	phase_t           phase_q;
	logic [AW-1:0]    clr_q;
	logic             init_q;
	logic [AW-1:0]    x_q;
	logic [AW-1:0]    b_q;
	logic [AW-1:0]    ra_q;
	logic [AW-1:0]    hi_q;
	entry_t           ex_q;
	entry_t           ea_q;
	entry_t           ehi_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] next_label_q;
	logic             stopped_q;
	logic             res_merged_q;
	logic [LBL_W-1:0] res_label_q;

	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	entry_t           wr_data;

	logic             at_root;
	logic             swap;
	logic [AW-1:0]    hi;
	logic [AW-1:0]    lo;
	entry_t           ehi;
	entry_t           elo;
	logic             need_rank;
	logic             edge_live;
	logic [CNT_W-1:0] count_dec;

	assign at_root   = rdata.parent == x_q;
	assign swap      = ea_q.rank < rdata.rank;
	assign hi        = swap ? x_q : ra_q;
	assign lo        = swap ? ra_q : x_q;
	assign ehi       = swap ? rdata : ea_q;
	assign elo       = swap ? ea_q : rdata;
	assign need_rank = (ea_q.rank == rdata.rank) && (ehi.rank < RANK_MAX);
	assign edge_live = !stopped_q && (count_q > CNT_W'(1));
	assign count_dec = count_q - CNT_W'(1);

	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign sweep_init = init_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = x_q;
		wr_en   = 1'b0;
		wr_addr = x_q;
		wr_data = rdata;
		unique case (state_q)
			S_CLEAR: begin
				wr_en          = 1'b1;
				wr_addr        = clr_q;
				wr_data        = '0;
				wr_data.parent = clr_q;
			end
			S_IDLE: begin
				rd_addr = AW'(q_item.a);
				rd_en   = q_valid && ((q_item.op == OP_LABEL) ||
					(q_item.op == OP_EDGE && edge_live));
			end
			S_WX: begin
				if (!at_root) begin
					rd_en   = 1'b1;
					rd_addr = rdata.parent;
				end else if (phase_q == PH_A) begin
					rd_en   = 1'b1;
					rd_addr = b_q;
				end else if (phase_q == PH_B) begin
					wr_en          = x_q != ra_q;
					wr_addr        = lo;
					wr_data        = elo;
					wr_data.parent = hi;
				end else begin
					wr_en          = !rdata.lvalid;
					wr_data.lvalid = 1'b1;
					wr_data.label  = next_label_q[LBL_W-1:0];
				end
			end
			S_WP: begin
				// Path halving: x now points to its grandparent and the walk
				// continues from there.
				wr_en          = 1'b1;
				wr_data        = ex_q;
				wr_data.parent = rdata.parent;
				rd_en          = 1'b1;
				rd_addr        = rdata.parent;
			end
			S_RANK: begin
				wr_en        = 1'b1;
				wr_addr      = hi_q;
				wr_data      = ehi_q;
				wr_data.rank = ehi_q.rank + RANK_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			phase_q       <= PH_A;
			clr_q         <= '0;
			init_q        <= 1'b1;
			x_q           <= '0;
			b_q           <= '0;
			ra_q          <= '0;
			hi_q          <= '0;
			ex_q          <= '0;
			ea_q          <= '0;
			ehi_q         <= '0;
			count_q       <= CNT_W'(RST_CNT);
			next_label_q  <= '0;
			stopped_q     <= 1'b0;
			res_merged_q  <= 1'b0;
			res_label_q   <= '0;
			out_valid     <= 1'b0;
			merged        <= 1'b0;
			components    <= '0;
			stopped       <= 1'b0;
			cluster_label <= '0;
		end else begin
			if (out_ready && state_q != S_EMIT) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						if (init_q) begin
							init_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							count_q      <= n_eff;
							next_label_q <= '0;
							stopped_q    <= 1'b0;
							state_q      <= S_EMIT;
						end
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						res_merged_q <= 1'b0;
						res_label_q  <= '0;
						x_q          <= AW'(q_item.a);
						b_q          <= AW'(q_item.b);
						unique case (q_item.op)
							OP_START: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
							OP_EDGE: begin
								phase_q <= PH_A;
								state_q <= edge_live ? S_WX : S_EMIT;
							end
							OP_LABEL: begin
								phase_q <= PH_L;
								state_q <= S_WX;
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_WX: begin
					if (!at_root) begin
						ex_q    <= rdata;
						state_q <= S_WP;
					end else if (phase_q == PH_A) begin
						ra_q    <= x_q;
						ea_q    <= rdata;
						x_q     <= b_q;
						phase_q <= PH_B;
					end else if (phase_q == PH_B) begin
						if (x_q == ra_q) begin
							state_q <= S_EMIT;
						end else begin
							hi_q         <= hi;
							ehi_q        <= ehi;
							count_q      <= count_dec;
							res_merged_q <= 1'b1;
							if (count_dec <= target) begin
								stopped_q <= 1'b1;
							end
							state_q <= need_rank ? S_RANK : S_EMIT;
						end
					end else begin
						if (!rdata.lvalid) begin
							res_label_q  <= next_label_q[LBL_W-1:0];
							next_label_q <= next_label_q + CNT_W'(1);
						end else begin
							res_label_q <= rdata.label;
						end
						state_q <= S_EMIT;
					end
				end
				S_WP: begin
					x_q     <= rdata.parent;
					state_q <= S_WX;
				end
				S_RANK: state_q <= S_EMIT;
				S_EMIT: begin
					if (!out_valid || out_ready) begin
						out_valid     <= 1'b1;
						merged        <= res_merged_q;
						components    <= count_q;
						stopped       <= stopped_q;
						cluster_label <= res_label_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/single_linkage_union_find.sv
`default_nettype none
// An edge walks both of its ends to their roots, with a rank write added when a rank
// grows, and a dropped edge skips the walks; a label walks its point to its root.
// A start command sweeps all MAX_POINTS entries, one a cycle, then reports.
// Items are handled one at a time; a two-entry queue buffers arrivals.
// After reset a clearing sweep of all MAX_POINTS entries runs with in_ready low;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// single_linkage_union_find
// Kruskal merging over a union-find forest with APB configuration.
// ----------------------------------------------------------------------------
module single_linkage_union_find
	import slf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       command,
	input  wire logic [IDX_W-1:0] point_index,
	input  wire logic [IDX_W-1:0] neighbor_index,
	input  wire logic             neighbor_valid,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  merged,
	output logic [CNT_W-1:0]      components,
	output logic                  stopped,
	output logic [LBL_W-1:0]      cluster_label
);

	logic [CNT_W-1:0] point_count_q;
	logic [CNT_W-1:0] target_q;
	logic [CNT_W-1:0] n_eff;
	logic             q_valid;
	work_t            q_item;
	logic             q_pop;
	logic             sweep_init;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(1024);
			target_q      <= CNT_W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_POINT_COUNT: point_count_q <= pwdata[CNT_W-1:0];
				REG_TARGET:      target_q      <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_POINT_COUNT: prdata = 32'(point_count_q);
			REG_TARGET:      prdata = 32'(target_q);
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		if (point_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(point_count_q) > MAX_POINTS) begin
			n_eff = CNT_W'(MAX_POINTS);
		end else begin
			n_eff = point_count_q;
		end
	end

	slf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.point_index    (point_index),
		.neighbor_index (neighbor_index),
		.neighbor_valid (neighbor_valid),
		.n_eff          (n_eff),
		.hold           (sweep_init),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	slf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.n_eff         (n_eff),
		.target        (target_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.sweep_init    (sweep_init),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.merged        (merged),
		.components    (components),
		.stopped       (stopped),
		.cluster_label (cluster_label)
	);

	// A merging edge never carries a label.
	a_merge_no_label: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && merged |-> cluster_label == '0)
		else $error("merged result carries a label");

	// An accepted item is in the queue on the next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> q_valid)
		else $error("accepted item missing from queue");

	// A merge never reports a component count of 2047 or above.
	a_merge_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && merged |-> components < 11'(2047))
		else $error("merge reported an impossible count");

endmodule
`default_nettype wire

### tb/tb_single_linkage_union_find.sv
// ----------------------------------------------------------------------------
// tb_single_linkage_union_find
// Self-checking bench for the union-find clustering block. A model of the
// forest is run in step with every accepted item and each result is compared
// field by field. Edge, label, start and unused commands are mixed under
// several point counts and targets, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module tb_single_linkage_union_find;
	import slf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = 1024;

	typedef struct {
		logic [1:0]       cmd;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic             nv;
		bit               drain;
	} edge_item_t;

	typedef struct {
		logic             merged;
		logic [CNT_W-1:0] comps;
		logic             stopped;
		logic [LBL_W-1:0] label;
	} cluster_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = '0;
	logic [IDX_W-1:0] point_index = '0, neighbor_index = '0;
	logic neighbor_valid = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic merged, stopped;
	logic [CNT_W-1:0] components;
	logic [LBL_W-1:0] cluster_label;

	single_linkage_union_find dut (.*);

	// Model of the forest and its configuration.
	logic [IDX_W-1:0]  m_parent[NPTS];
	logic [RANK_W-1:0] m_rank[NPTS];
	logic [LBL_W-1:0]  m_label[NPTS];
	bit                m_label_ok[NPTS];
	logic [CNT_W-1:0]  m_comps, m_next_label;
	bit                m_stopped;
	logic [CNT_W-1:0]  cfg_points = 11'd1024, cfg_target = 11'd1;

	edge_item_t      pending_items[$];
	cluster_result_t expected_results[$];
	edge_item_t      cur;
	int errors = 0, total_items = 0, n_merges = 0, n_labels = 0, n_starts = 0;
	int in_gap = 0, out_gap = 0;
	bit no_idle = 0;

	initial forever #4 clk = ~clk;

	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int live_points();
		if (cfg_points < 1) return 1;
		if (cfg_points > NPTS) return NPTS;
		return int'(cfg_points);
	endfunction

	function automatic void clear_forest();
		for (int i = 0; i < NPTS; i++) begin
			m_parent[i] = IDX_W'(i);
			m_rank[i] = '0;
			m_label[i] = '0;
			m_label_ok[i] = 0;
		end
		m_comps = CNT_W'(live_points());
		m_next_label = '0;
		m_stopped = 0;
	endfunction

	// Root search with path halving, as the hardware walks it.
	function automatic int root_of(int x);
		int guard;
		guard = 0;
		while (m_parent[x] != x && guard < NPTS) begin
			m_parent[x] = m_parent[m_parent[x]];
			x = int'(m_parent[x]);
			guard++;
		end
		return x;
	endfunction

	function automatic cluster_result_t cluster_step(edge_item_t it);
		cluster_result_t res;
		int n, ra, rb, t;
		n = live_points();
		res.merged = 0;
		res.label = '0;
		if (it.cmd == CMD_START) begin
			clear_forest();
			n_starts++;
		end else if (it.cmd == CMD_EDGE) begin
			if (it.nv && it.b > it.a && it.a < n && it.b < n && !m_stopped && m_comps > 1) begin
				ra = root_of(int'(it.a));
				rb = root_of(int'(it.b));
				if (ra != rb) begin
					if (m_rank[ra] < m_rank[rb]) begin
						t = ra;
						ra = rb;
						rb = t;
					end
					m_parent[rb] = IDX_W'(ra);
					if (m_rank[ra] == m_rank[rb] && m_rank[ra] < RANK_MAX)
						m_rank[ra]++;
					m_comps--;
					res.merged = 1;
					n_merges++;
					if (m_comps <= cfg_target)
						m_stopped = 1;
				end
			end
		end else if (it.cmd == CMD_LABEL) begin
			if (it.a < n) begin
				ra = root_of(int'(it.a));
				if (!m_label_ok[ra]) begin
					m_label[ra] = m_next_label[LBL_W-1:0];
					m_label_ok[ra] = 1;
					m_next_label = m_next_label + 1'b1;
				end
				res.label = m_label[ra];
				n_labels++;
			end
		end
		res.comps = m_comps;
		res.stopped = m_stopped;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: one assignment per signal per edge.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			expected_results.insert(expected_results.size(), cluster_step(cur));
		if (in_valid && !in_ready) begin
		end else if (in_gap > 0) begin
			in_gap--;
			in_valid <= 1'b0;
		end else if (arst_n && pending_items.size() > 0 &&
				!(pending_items[0].drain && expected_results.size() > 0)) begin
			cur = pending_items.pop_front();
			command <= cur.cmd;
			point_index <= cur.a;
			neighbor_index <= cur.b;
			neighbor_valid <= cur.nv;
			in_valid <= 1'b1;
			in_gap = pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Monitor.
	always @(posedge clk) begin
		cluster_result_t exp_r;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no item waiting");
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (merged !== exp_r.merged) begin
					$error("merged: expected %0d, got %0d", exp_r.merged, merged);
					errors++;
				end
				if (components !== exp_r.comps) begin
					$error("components: expected %0d, got %0d", exp_r.comps, components);
					errors++;
				end
				if (stopped !== exp_r.stopped) begin
					$error("stopped: expected %0d, got %0d", exp_r.stopped, stopped);
					errors++;
				end
				if (cluster_label !== exp_r.label) begin
					$error("cluster_label: expected %0d, got %0d", exp_r.label,
						cluster_label);
					errors++;
				end
			end
		end
		if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			out_gap = pick_gap();
		end
	end

	task automatic reg_write(logic idx, logic [CNT_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_POINT_COUNT) cfg_points = val;
		else cfg_target = val;
	endtask

	task automatic add_item(logic [1:0] cmd, int a, int b, logic nv, bit drain = 0);
		edge_item_t it;
		it.cmd = cmd;
		it.a = IDX_W'(a);
		it.b = IDX_W'(b);
		it.nv = nv;
		it.drain = drain;
		pending_items.insert(pending_items.size(), it);
		total_items++;
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_job();
		int n, ne, a, b;
		logic [CNT_W-1:0] pc;
		pc = CNT_W'($urandom_range(2, 24));
		case ($urandom_range(0, 9))
			0: pc = 11'd1024;
			1: pc = CNT_W'($urandom_range(1025, 2047));
			2: pc = CNT_W'($urandom_range(0, 1));
			default: ;
		endcase
		reg_write(REG_POINT_COUNT, pc);
		n = live_points();
		case ($urandom_range(0, 5))
			0: reg_write(REG_TARGET, 11'd0);
			1: reg_write(REG_TARGET, 11'd2047);
			default: reg_write(REG_TARGET, CNT_W'($urandom_range(1, n)));
		endcase
		no_idle = ($urandom_range(0, 3) == 0);
		add_item(CMD_START, $urandom_range(0, 1023), $urandom_range(0, 1023),
			1'($urandom));
		ne = (n > 30) ? 40 : 2 * n;
		for (int i = 0; i < ne; i++) begin
			if ($urandom_range(0, 99) < 85 && n > 1) begin
				a = $urandom_range(0, n - 2);
				b = $urandom_range(a + 1, n - 1);
				add_item(CMD_EDGE, a, b, 1'b1, $urandom_range(0, 49) == 0);
			end else begin
				add_item(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
					$urandom_range(0, 1023), 1'($urandom));
			end
		end
		for (int i = 0; i < ((n > 30) ? 30 : n); i++)
			add_item(CMD_LABEL, ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : i,
				$urandom_range(0, 1023), 1'($urandom));
		wait_idle();
	endtask

	initial begin
		int waited;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		clear_forest();

		// Directed: six points, target zero so merging never stops on its own.
		reg_write(REG_POINT_COUNT, 11'd6);
		reg_write(REG_TARGET, 11'd0);
		add_item(CMD_START, 0, 0, 0);
		add_item(CMD_EDGE, 0, 1, 1);
		add_item(CMD_EDGE, 1, 0, 1);
		add_item(CMD_EDGE, 2, 3, 0);
		add_item(CMD_EDGE, 4, 9, 1);
		add_item(CMD_EDGE, 0, 1, 1);
		add_item(2'(OP_NOP), 1023, 1023, 1);
		add_item(CMD_LABEL, 5, 0, 0);
		add_item(CMD_LABEL, 9, 0, 0, 1);
		add_item(CMD_EDGE, 2, 3, 1);
		add_item(CMD_EDGE, 3, 4, 1);
		add_item(CMD_EDGE, 4, 5, 1);
		add_item(CMD_EDGE, 1, 5, 1);
		add_item(CMD_LABEL, 0, 0, 1);
		add_item(CMD_LABEL, 2, 0, 1);
		wait_idle();
		// Raising the count mid-job: one component left, so no further merge.
		reg_write(REG_POINT_COUNT, 11'd12);
		add_item(CMD_EDGE, 6, 7, 1);
		add_item(CMD_LABEL, 7, 0, 1);
		wait_idle();
		// Count already below target: the first uniting edge merges and stops.
		reg_write(REG_POINT_COUNT, 11'd2047);
		reg_write(REG_TARGET, 11'd2047);
		add_item(CMD_START, 1023, 0, 0);
		add_item(CMD_EDGE, 1022, 1023, 1);
		add_item(CMD_EDGE, 0, 1, 1);
		add_item(CMD_LABEL, 1023, 1023, 1);
		wait_idle();
		reg_write(REG_POINT_COUNT, 11'd0);
		reg_write(REG_TARGET, 11'd1);
		add_item(CMD_START, 0, 0, 0);
		add_item(CMD_EDGE, 0, 1, 1);
		add_item(CMD_LABEL, 0, 0, 0);
		add_item(CMD_LABEL, 1, 0, 0);
		wait_idle();

		while (total_items < 500)
			random_job();

		waited = 0;
		while (expected_results.size() > 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2000) @(posedge clk);
		if (expected_results.size() > 0) begin
			$error("%0d results never arrived", expected_results.size());
			errors++;
		end
		$display("Ran %0d items: %0d job starts, %0d merges, %0d labelled points.",
			total_items, n_starts, n_merges, n_labels);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### single_linkage_union_find.f
rtl/slf_pkg.sv
rtl/slf_front.sv
rtl/slf_back.sv
rtl/single_linkage_union_find.sv
tb/tb_single_linkage_union_find.sv
